// ===== rtl/core/trr_pkg.sv =====
// Package for the TFTP read receiver: codes, payload structs and shared constants.
// No dependencies; every other file of the block but trr_ifs imports it.
package trr_pkg;

    localparam int unsigned TRR_DEFAULT_BLOCK_SIZE = 512;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLKSIZE_REQUEST = 2'd0,
        CFG_TIMEOUT_REQUEST = 2'd1,
        CFG_TSIZE_REQUEST   = 2'd2,
        CFG_DALLY_ENABLE    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_DATA  = 2'd1,
        FUNC_ACK   = 2'd2,
        FUNC_OACK  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SEND_NONE = 2'd0,
        SEND_ACK  = 2'd1,
        SEND_ERR  = 2'd2,
        SEND_RRQ  = 2'd3
    } send_kind_t;

    typedef enum logic [1:0] {
        ERR_ILLEGAL_OP     = 2'd0,
        ERR_OPTION_REFUSED = 2'd1,
        ERR_DISK_FULL      = 2'd2
    } error_code_t;

    typedef enum logic [3:0] {
        FR_NONE            = 4'd0,
        FR_WRONG_BLOCK     = 4'd1,
        FR_TOO_MUCH_DATA   = 4'd2,
        FR_NO_OPTIONS      = 4'd3,
        FR_ACK_UNEXPECTED  = 4'd4,
        FR_OACK_AFTER_DATA = 4'd5,
        FR_EMPTY_OACK      = 4'd6,
        FR_BLKSIZE_UNEXP   = 4'd7,
        FR_OPTION_INVALID  = 4'd8,
        FR_BLKSIZE_ABOVE   = 4'd9,
        FR_TIMEOUT_UNEXP   = 4'd10,
        FR_TIMEOUT_DIFFERS = 4'd11,
        FR_TSIZE_UNEXP     = 4'd12,
        FR_TSIZE_REFUSED   = 4'd13,
        FR_APP_REFUSED     = 4'd14,
        FR_UNKNOWN_OPTIONS = 4'd15
    } fault_reason_t;

    typedef enum logic [1:0] {
        WAIT_RECEIVE  = 2'd0,
        WAIT_DALLY    = 2'd1,
        WAIT_FINISHED = 2'd2
    } next_wait_t;

    typedef enum logic [1:0] {
        ST_IN_PROGRESS = 2'd0,
        ST_SUCCESS     = 2'd1,
        ST_XFER_ERROR  = 2'd2,
        ST_OPTION_ERROR = 2'd3
    } status_t;

    // Bit positions inside option_flags.
    localparam int unsigned OPT_LIST_EMPTY = 0;
    localparam int unsigned OPT_BLK_PRES   = 1;
    localparam int unsigned OPT_BLK_OK     = 2;
    localparam int unsigned OPT_TMO_PRES   = 3;
    localparam int unsigned OPT_TMO_OK     = 4;
    localparam int unsigned OPT_TSZ_PRES   = 5;
    localparam int unsigned OPT_TSZ_OK     = 6;
    localparam int unsigned OPT_UNKNOWN    = 7;

    typedef struct packed {
        func_t       func;
        logic [15:0] block_number;
        logic [15:0] data_size;
        logic [15:0] blksize_value;
        logic [7:0]  timeout_value;
        logic [7:0]  option_flags;
        logic        size_accepted;
        logic        app_accepts;
    } pkt_t;

    typedef struct packed {
        send_kind_t    send_kind;
        logic [15:0]   ack_block;
        error_code_t   error_code;
        fault_reason_t fault_reason;
        logic          deliver_data;
        next_wait_t    next_wait;
        status_t       status;
    } res_t;

    typedef struct packed {
        logic [15:0] blksize_request;
        logic [7:0]  timeout_request;
        logic        tsize_request;
        logic        dally_enable;
    } cfg_t;

    // Handshake between the input register and the engine.
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

// ===== rtl/core/trr_ifs.sv =====
// Channel interfaces of the TFTP read receiver: packet events in, results out.
// Field widths follow trr_pkg; no other dependencies.
interface trr_pkt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] block_number;
    logic [15:0] data_size;
    logic [15:0] blksize_value;
    logic [7:0]  timeout_value;
    logic [7:0]  option_flags;
    logic        size_accepted;
    logic        app_accepts;

    modport source (
        output valid, func, block_number, data_size, blksize_value,
               timeout_value, option_flags, size_accepted, app_accepts,
        input  ready
    );
    modport sink (
        input  valid, func, block_number, data_size, blksize_value,
               timeout_value, option_flags, size_accepted, app_accepts,
        output ready
    );
endinterface

interface trr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  send_kind;
    logic [15:0] ack_block;
    logic [1:0]  error_code;
    logic [3:0]  fault_reason;
    logic        deliver_data;
    logic [1:0]  next_wait;
    logic [1:0]  status;

    modport source (
        output valid, send_kind, ack_block, error_code, fault_reason,
               deliver_data, next_wait, status,
        input  ready
    );
    modport sink (
        input  valid, send_kind, ack_block, error_code, fault_reason,
               deliver_data, next_wait, status,
        output ready
    );
endinterface

// ===== rtl/core/tftp_read_receiver.sv =====
// TFTP read receiver top level: configuration registers, input register, engine, result register.
// Depends on trr_pkg, trr_ifs and the trr_* modules.
//
// Usage: decoded packet events (start, DATA, ACK, OACK) arrive on the pkt channel, one per
// transfer when valid and ready are both high. Each event yields exactly one result on the
// res channel: what to send (nothing, ACK, ERROR or read request), the ACK block, the error
// code and fault reason, whether to deliver the DATA payload, what to wait for next, and the
// transfer status.
// An event is captured in the input register, decided by the engine there and loaded into
// the result register when that register can take it, where it is visible at once.
// Throughput is one event per cycle while res.ready stays high; the engine's state update is
// the only loop, so back-to-back events always see the state left by their predecessor.
// If the sink stalls, the result register holds its result, the input register fills behind
// it, and pkt.ready drops until res.ready returns.
// The option requests and dally enable are written through cfg_we, cfg_index and cfg_data
// while no event is in flight; the user must keep to this, the block does not enforce it.
// Reset clears both channels and sets the phase to idle, the last block to zero and the
// receive size to DEFAULT_BLOCK_SIZE; the block accepts events in the first cycle after reset.
module tftp_read_receiver
    import trr_pkg::*;
#(
    parameter int unsigned DEFAULT_BLOCK_SIZE = TRR_DEFAULT_BLOCK_SIZE
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    trr_pkt_if.sink                pkt,
    trr_res_if.source              res,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg;
    stage_ctl_t ctl;
    pkt_t       item;
    res_t       result;
    logic       advance;
    logic       fire;

    trr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trr_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt),
        .advance (advance),
        .ctl     (ctl),
        .item    (item)
    );

    trr_engine #(
        .DEFAULT_BLOCK_SIZE (DEFAULT_BLOCK_SIZE)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .ctl   (ctl),
        .item  (item),
        .fire  (fire),
        .res   (result)
    );

    trr_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .res_in  (result),
        .advance (advance),
        .res     (res)
    );

endmodule

// ===== rtl/core/trr_cfg_regs.sv =====
// Configuration registers of the TFTP read receiver, written through a plain write port.
// Depends on trr_pkg.
module trr_cfg_regs
    import trr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BLKSIZE_REQUEST: cfg_next.blksize_request = cfg_data[15:0];
                CFG_TIMEOUT_REQUEST: cfg_next.timeout_request = cfg_data[7:0];
                CFG_TSIZE_REQUEST:   cfg_next.tsize_request   = cfg_data[0];
                CFG_DALLY_ENABLE:    cfg_next.dally_enable    = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/trr_in_reg.sv =====
// Input register of the TFTP read receiver: captures one packet event per transfer.
// Depends on trr_pkg and trr_pkt_if.
module trr_in_reg
    import trr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    trr_pkt_if.sink    pkt,
    input  logic       advance,
    output stage_ctl_t ctl,
    output pkt_t       item
);

    logic valid_reg;
    logic valid_next;
    pkt_t item_reg;
    logic load;

    // The slot can take a new event when empty or when its item moves on this cycle.
    assign pkt.ready = !valid_reg || advance;
    assign load      = pkt.valid && pkt.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.func          <= func_t'(pkt.func);
            item_reg.block_number  <= pkt.block_number;
            item_reg.data_size     <= pkt.data_size;
            item_reg.blksize_value <= pkt.blksize_value;
            item_reg.timeout_value <= pkt.timeout_value;
            item_reg.option_flags  <= pkt.option_flags;
            item_reg.size_accepted <= pkt.size_accepted;
            item_reg.app_accepts   <= pkt.app_accepts;
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign item        = item_reg;

endmodule

// ===== rtl/core/trr_engine.sv =====
// Protocol engine of the TFTP read receiver: transfer state and the per-packet decision.
// Depends on trr_pkg.
module trr_engine
    import trr_pkg::*;
#(
    parameter int unsigned DEFAULT_BLOCK_SIZE = TRR_DEFAULT_BLOCK_SIZE
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  stage_ctl_t ctl,
    input  pkt_t       item,
    output logic       fire,
    output res_t       res
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RECV  = 2'd1,
        PH_DALLY = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    logic [15:0] last_block_reg;
    logic [15:0] last_block_next;
    logic [15:0] receive_size_reg;
    logic [15:0] receive_size_next;
    logic        oack_seen_reg;
    logic        oack_seen_next;
    phase_t      phase_reg;
    phase_t      phase_next;

    logic [15:0]   next_block;
    logic [15:0]   ack_value;
    logic          ack_go;
    logic          ack_deliver;
    fault_reason_t fault;
    logic          b_pres, b_ok, t_pres, t_ok, s_pres, s_ok;

    assign fire = ctl.valid && ctl.advance;

    assign next_block = last_block_reg + 16'd1;
    assign b_pres = item.option_flags[OPT_BLK_PRES];
    assign b_ok   = item.option_flags[OPT_BLK_OK];
    assign t_pres = item.option_flags[OPT_TMO_PRES];
    assign t_ok   = item.option_flags[OPT_TMO_OK];
    assign s_pres = item.option_flags[OPT_TSZ_PRES];
    assign s_ok   = item.option_flags[OPT_TSZ_OK];

    always_comb
    begin
        last_block_next   = last_block_reg;
        receive_size_next = receive_size_reg;
        oack_seen_next    = oack_seen_reg;
        phase_next        = phase_reg;
        res               = '0;
        fault             = FR_NONE;
        ack_go            = 1'b0;
        ack_value         = last_block_reg;
        ack_deliver       = 1'b0;

        if (item.func == FUNC_START)
        begin
            last_block_next   = '0;
            receive_size_next = 16'(DEFAULT_BLOCK_SIZE);
            oack_seen_next    = 1'b0;
            phase_next        = PH_RECV;
            res.send_kind     = SEND_RRQ;
        end
        else if (phase_reg != PH_RECV && phase_reg != PH_DALLY)
        begin
            res.next_wait = WAIT_FINISHED;
        end
        else
        begin
            unique case (item.func)
                FUNC_DATA:
                begin
                    // A repeat of the last block is acknowledged again, not delivered.
                    priority if (item.block_number == last_block_reg)
                    begin
                        ack_go = 1'b1;
                    end
                    else if (item.block_number != next_block)
                    begin
                        fault = FR_WRONG_BLOCK;
                    end
                    else if (item.data_size > receive_size_reg)
                    begin
                        fault = FR_TOO_MUCH_DATA;
                    end
                    else if (item.block_number == 16'd1 && !oack_seen_reg
                             && !item.app_accepts)
                    begin
                        fault = FR_NO_OPTIONS;
                    end
                    else
                    begin
                        last_block_next = item.block_number;
                        ack_value       = item.block_number;
                        ack_deliver     = 1'b1;
                        ack_go          = 1'b1;
                    end
                end
                FUNC_ACK:
                begin
                    fault = FR_ACK_UNEXPECTED;
                end
                FUNC_OACK:
                begin
                    priority if (last_block_reg != 16'd0)
                    begin
                        fault = FR_OACK_AFTER_DATA;
                    end
                    else if (item.option_flags[OPT_LIST_EMPTY])
                    begin
                        fault = FR_EMPTY_OACK;
                    end
                    else if (cfg.blksize_request == 16'd0 && b_pres && b_ok)
                    begin
                        fault = FR_BLKSIZE_UNEXP;
                    end
                    else if (b_pres && !b_ok)
                    begin
                        fault = FR_OPTION_INVALID;
                    end
                    else if (b_pres && item.blksize_value > cfg.blksize_request)
                    begin
                        fault = FR_BLKSIZE_ABOVE;
                    end
                    else
                    begin
                        // The block size sticks even when a later option check fails.
                        if (b_pres)
                        begin
                            receive_size_next = item.blksize_value;
                        end
                        priority if (cfg.timeout_request == 8'd0 && t_pres && t_ok)
                        begin
                            fault = FR_TIMEOUT_UNEXP;
                        end
                        else if (t_pres && !t_ok)
                        begin
                            fault = FR_OPTION_INVALID;
                        end
                        else if (t_pres && item.timeout_value != cfg.timeout_request)
                        begin
                            fault = FR_TIMEOUT_DIFFERS;
                        end
                        else if (!cfg.tsize_request && s_pres && s_ok)
                        begin
                            fault = FR_TSIZE_UNEXP;
                        end
                        else if (s_pres && !s_ok)
                        begin
                            fault = FR_OPTION_INVALID;
                        end
                        else if (s_pres && !item.size_accepted)
                        begin
                            fault = FR_TSIZE_REFUSED;
                        end
                        else if (!item.app_accepts)
                        begin
                            fault = FR_APP_REFUSED;
                        end
                        else if (item.option_flags[OPT_UNKNOWN])
                        begin
                            fault = FR_UNKNOWN_OPTIONS;
                        end
                        else
                        begin
                            oack_seen_next = 1'b1;
                            phase_next     = PH_RECV;
                            res.send_kind  = SEND_ACK;
                        end
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase

            if (fault != FR_NONE)
            begin
                phase_next       = PH_DONE;
                res.send_kind    = SEND_ERR;
                res.fault_reason = fault;
                res.next_wait    = WAIT_FINISHED;
                priority if (fault == FR_WRONG_BLOCK || fault == FR_TOO_MUCH_DATA
                             || fault == FR_ACK_UNEXPECTED
                             || fault == FR_OACK_AFTER_DATA || fault == FR_EMPTY_OACK)
                begin
                    res.error_code = ERR_ILLEGAL_OP;
                    res.status     = ST_XFER_ERROR;
                end
                else if (fault == FR_NO_OPTIONS)
                begin
                    res.error_code = ERR_OPTION_REFUSED;
                    res.status     = ST_XFER_ERROR;
                end
                else if (fault == FR_TSIZE_REFUSED)
                begin
                    res.error_code = ERR_DISK_FULL;
                    res.status     = ST_OPTION_ERROR;
                end
                else
                begin
                    res.error_code = ERR_OPTION_REFUSED;
                    res.status     = ST_OPTION_ERROR;
                end
            end

            // A short block ends the transfer, or waits for a retry when dallying.
            if (ack_go)
            begin
                res.send_kind    = SEND_ACK;
                res.ack_block    = ack_value;
                res.deliver_data = ack_deliver;
                if (item.data_size < receive_size_reg)
                begin
                    if (cfg.dally_enable)
                    begin
                        phase_next    = PH_DALLY;
                        res.next_wait = WAIT_DALLY;
                    end
                    else
                    begin
                        phase_next    = PH_DONE;
                        res.next_wait = WAIT_FINISHED;
                        res.status    = ST_SUCCESS;
                    end
                end
                else
                begin
                    phase_next = PH_RECV;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_block_reg   <= '0;
            receive_size_reg <= 16'(DEFAULT_BLOCK_SIZE);
            oack_seen_reg    <= 1'b0;
            phase_reg        <= PH_IDLE;
        end
        else if (fire)
        begin
            last_block_reg   <= last_block_next;
            receive_size_reg <= receive_size_next;
            oack_seen_reg    <= oack_seen_next;
            phase_reg        <= phase_next;
        end
    end

endmodule

// ===== rtl/core/trr_out_reg.sv =====
// Result register of the TFTP read receiver: holds one result until the sink takes it.
// Depends on trr_pkg and trr_res_if.
module trr_out_reg
    import trr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  res_t      res_in,
    output logic      advance,
    trr_res_if.source res
);

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    // The engine may hand over a result whenever this register is empty or empties this cycle.
    assign advance = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= res_in;
        end
    end

    assign res.valid        = valid_reg;
    assign res.send_kind    = data_reg.send_kind;
    assign res.ack_block    = data_reg.ack_block;
    assign res.error_code   = data_reg.error_code;
    assign res.fault_reason = data_reg.fault_reason;
    assign res.deliver_data = data_reg.deliver_data;
    assign res.next_wait    = data_reg.next_wait;
    assign res.status       = data_reg.status;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for tftp_read_receiver: directed table, random packet sessions, then a plain transfer.
// Depends on trr_pkg, trr_ifs and the receiver RTL; results are checked against a local model.
module tb_top;
    import trr_pkg::*;

    typedef enum logic [1:0] {
        XF_IDLE  = 2'd0,
        XF_RECV  = 2'd1,
        XF_DALLY = 2'd2,
        XF_DONE  = 2'd3
    } xfer_phase_t;

    typedef struct {
        bit   is_cfg;
        cfg_t cfg;
        pkt_t pkt;
        bit   typed;
        res_t want;
    } stim_row_t;

    localparam logic [7:0] F_EMPTY = 8'(1 << OPT_LIST_EMPTY);
    localparam logic [7:0] F_BLK   = 8'((1 << OPT_BLK_PRES) | (1 << OPT_BLK_OK));
    localparam logic [7:0] F_TMO   = 8'((1 << OPT_TMO_PRES) | (1 << OPT_TMO_OK));
    localparam logic [7:0] F_TSZ   = 8'((1 << OPT_TSZ_PRES) | (1 << OPT_TSZ_OK));
    localparam logic [7:0] F_UNK   = 8'(1 << OPT_UNKNOWN);
    localparam res_t NO_RES = '0;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    trr_pkt_if pkt_ch ();
    trr_res_if res_ch ();

    tftp_read_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Model copy of the receiver state and its registers.
    logic [15:0] m_last;
    logic [15:0] m_rxsize;
    logic        m_oack;
    xfer_phase_t m_phase;
    cfg_t        tb_cfg;

    res_t      pending_res[$];
    stim_row_t dir_tab[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_req;
    int        hold_left;
    int        mism_count;
    int        live_count;

    function automatic res_t mk_res(send_kind_t k, logic [15:0] ack, error_code_t ec,
                                    fault_reason_t fr, logic dlv, next_wait_t w, status_t s);
        res_t r;
        r.send_kind    = k;
        r.ack_block    = ack;
        r.error_code   = ec;
        r.fault_reason = fr;
        r.deliver_data = dlv;
        r.next_wait    = w;
        r.status       = s;
        return r;
    endfunction

    function automatic res_t mk_err(error_code_t ec, fault_reason_t fr, status_t s);
        return mk_res(SEND_ERR, 16'd0, ec, fr, 1'b0, WAIT_FINISHED, s);
    endfunction

    function automatic pkt_t mk_pkt(func_t f, logic [15:0] blk, logic [15:0] size,
                                    logic [15:0] bval, logic [7:0] tval, logic [7:0] flags,
                                    logic sacc, logic app);
        pkt_t p;
        p.func          = f;
        p.block_number  = blk;
        p.data_size     = size;
        p.blksize_value = bval;
        p.timeout_value = tval;
        p.option_flags  = flags;
        p.size_accepted = sacc;
        p.app_accepts   = app;
        return p;
    endfunction

    function automatic res_t fault_res(error_code_t ec, fault_reason_t fr, status_t s);
        m_phase = XF_DONE;
        return mk_err(ec, fr, s);
    endfunction

    // Acknowledge, then continue, dally or finish depending on the block length.
    function automatic res_t ack_res(logic [15:0] blk, logic [15:0] size, logic dlv);
        if (size < m_rxsize) begin
            if (tb_cfg.dally_enable) begin
                m_phase = XF_DALLY;
                return mk_res(SEND_ACK, blk, ERR_ILLEGAL_OP, FR_NONE, dlv, WAIT_DALLY,
                              ST_IN_PROGRESS);
            end
            m_phase = XF_DONE;
            return mk_res(SEND_ACK, blk, ERR_ILLEGAL_OP, FR_NONE, dlv, WAIT_FINISHED,
                          ST_SUCCESS);
        end
        m_phase = XF_RECV;
        return mk_res(SEND_ACK, blk, ERR_ILLEGAL_OP, FR_NONE, dlv, WAIT_RECEIVE,
                      ST_IN_PROGRESS);
    endfunction

    function automatic res_t decide_event(pkt_t p);
        res_t        r;
        logic [15:0] nxt;
        logic        bp, bk, tp, tk, sp, sk;
        r   = '0;
        nxt = m_last + 16'd1;
        bp  = p.option_flags[OPT_BLK_PRES];
        bk  = p.option_flags[OPT_BLK_OK];
        tp  = p.option_flags[OPT_TMO_PRES];
        tk  = p.option_flags[OPT_TMO_OK];
        sp  = p.option_flags[OPT_TSZ_PRES];
        sk  = p.option_flags[OPT_TSZ_OK];
        if (p.func == FUNC_START) begin
            m_last   = 16'd0;
            m_rxsize = 16'(TRR_DEFAULT_BLOCK_SIZE);
            m_oack   = 1'b0;
            m_phase  = XF_RECV;
            r.send_kind = SEND_RRQ;
            return r;
        end
        if (m_phase == XF_IDLE || m_phase == XF_DONE) begin
            r.next_wait = WAIT_FINISHED;
            return r;
        end
        if (p.func == FUNC_ACK)
            return fault_res(ERR_ILLEGAL_OP, FR_ACK_UNEXPECTED, ST_XFER_ERROR);
        if (p.func == FUNC_DATA) begin
            if (p.block_number == m_last)
                return ack_res(m_last, p.data_size, 1'b0);
            if (p.block_number != nxt)
                return fault_res(ERR_ILLEGAL_OP, FR_WRONG_BLOCK, ST_XFER_ERROR);
            if (p.data_size > m_rxsize)
                return fault_res(ERR_ILLEGAL_OP, FR_TOO_MUCH_DATA, ST_XFER_ERROR);
            if (p.block_number == 16'd1 && !m_oack && !p.app_accepts)
                return fault_res(ERR_OPTION_REFUSED, FR_NO_OPTIONS, ST_XFER_ERROR);
            m_last = p.block_number;
            return ack_res(m_last, p.data_size, 1'b1);
        end
        // OACK: each option is checked in turn; the block size sticks once accepted.
        if (m_last != 16'd0)
            return fault_res(ERR_ILLEGAL_OP, FR_OACK_AFTER_DATA, ST_XFER_ERROR);
        if (p.option_flags[OPT_LIST_EMPTY])
            return fault_res(ERR_ILLEGAL_OP, FR_EMPTY_OACK, ST_XFER_ERROR);
        if (tb_cfg.blksize_request == 16'd0 && bp && bk)
            return fault_res(ERR_OPTION_REFUSED, FR_BLKSIZE_UNEXP, ST_OPTION_ERROR);
        if (bp && !bk)
            return fault_res(ERR_OPTION_REFUSED, FR_OPTION_INVALID, ST_OPTION_ERROR);
        if (bp && p.blksize_value > tb_cfg.blksize_request)
            return fault_res(ERR_OPTION_REFUSED, FR_BLKSIZE_ABOVE, ST_OPTION_ERROR);
        if (bp)
            m_rxsize = p.blksize_value;
        if (tb_cfg.timeout_request == 8'd0 && tp && tk)
            return fault_res(ERR_OPTION_REFUSED, FR_TIMEOUT_UNEXP, ST_OPTION_ERROR);
        if (tp && !tk)
            return fault_res(ERR_OPTION_REFUSED, FR_OPTION_INVALID, ST_OPTION_ERROR);
        if (tp && p.timeout_value != tb_cfg.timeout_request)
            return fault_res(ERR_OPTION_REFUSED, FR_TIMEOUT_DIFFERS, ST_OPTION_ERROR);
        if (!tb_cfg.tsize_request && sp && sk)
            return fault_res(ERR_OPTION_REFUSED, FR_TSIZE_UNEXP, ST_OPTION_ERROR);
        if (sp && !sk)
            return fault_res(ERR_OPTION_REFUSED, FR_OPTION_INVALID, ST_OPTION_ERROR);
        if (sp && !p.size_accepted)
            return fault_res(ERR_DISK_FULL, FR_TSIZE_REFUSED, ST_OPTION_ERROR);
        if (!p.app_accepts)
            return fault_res(ERR_OPTION_REFUSED, FR_APP_REFUSED, ST_OPTION_ERROR);
        if (p.option_flags[OPT_UNKNOWN])
            return fault_res(ERR_OPTION_REFUSED, FR_UNKNOWN_OPTIONS, ST_OPTION_ERROR);
        m_oack  = 1'b1;
        m_phase = XF_RECV;
        r.send_kind = SEND_ACK;
        return r;
    endfunction

    function automatic string fmt_res(res_t r);
        return $sformatf("kind=%0d ack=%0d err=%0d fault=%0d deliver=%0b wait=%0d status=%0d",
                         r.send_kind, r.ack_block, r.error_code, r.fault_reason,
                         r.deliver_data, r.next_wait, r.status);
    endfunction

    task automatic take_result();
        res_t got;
        res_t want;
        got.send_kind    = send_kind_t'(res_ch.send_kind);
        got.ack_block    = res_ch.ack_block;
        got.error_code   = error_code_t'(res_ch.error_code);
        got.fault_reason = fault_reason_t'(res_ch.fault_reason);
        got.deliver_data = res_ch.deliver_data;
        got.next_wait    = next_wait_t'(res_ch.next_wait);
        got.status       = status_t'(res_ch.status);
        if (pending_res.size() == 0) begin
            mism_count++;
            if (mism_count <= 10)
                $display("result with none expected: %s", fmt_res(got));
        end
        else begin
            want = pending_res.pop_front();
            if (got !== want) begin
                mism_count++;
                if (mism_count <= 10)
                    $display("mismatch: expected %s, got %s", fmt_res(want), fmt_res(got));
            end
        end
    endtask

    // Result side: check every transfer, drop ready at random or for a requested hold-off.
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready)
                take_result();
            if (hold_req) begin
                hold_left = 60;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_pkt(input pkt_t p, input bit typed, input res_t want);
        res_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            pkt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_ch.valid         <= 1'b1;
        pkt_ch.func          <= p.func;
        pkt_ch.block_number  <= p.block_number;
        pkt_ch.data_size     <= p.data_size;
        pkt_ch.blksize_value <= p.blksize_value;
        pkt_ch.timeout_value <= p.timeout_value;
        pkt_ch.option_flags  <= p.option_flags;
        pkt_ch.size_accepted <= p.size_accepted;
        pkt_ch.app_accepts   <= p.app_accepts;
        @(posedge clk);
        while (!pkt_ch.ready)
            @(posedge clk);
        if (p.func == FUNC_START || m_phase inside {XF_RECV, XF_DALLY})
            live_count++;
        r = decide_event(p);
        pending_res.push_back(typed ? want : r);
    endtask

    task automatic wait_drained();
        pkt_ch.valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BLKSIZE_REQUEST;
        cfg_data  <= c.blksize_request;
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT_REQUEST;
        cfg_data  <= CFG_DATA_W'(c.timeout_request);
        @(posedge clk);
        cfg_index <= CFG_TSIZE_REQUEST;
        cfg_data  <= CFG_DATA_W'(c.tsize_request);
        @(posedge clk);
        cfg_index <= CFG_DALLY_ENABLE;
        cfg_data  <= CFG_DATA_W'(c.dally_enable);
        @(posedge clk);
        cfg_we <= 1'b0;
        tb_cfg = c;
    endtask

    function automatic pkt_t rand_pkt();
        pkt_t p;
        p.func          = func_t'($urandom_range(3));
        p.block_number  = 16'($urandom);
        p.data_size     = 16'($urandom);
        p.blksize_value = 16'($urandom_range(65464));
        p.timeout_value = 8'($urandom);
        p.option_flags  = 8'($urandom);
        p.size_accepted = 1'($urandom);
        p.app_accepts   = 1'($urandom);
        return p;
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        case ($urandom_range(3))
            0: c.blksize_request = 16'd0;
            1: c.blksize_request = 16'd65464;
            2: c.blksize_request = 16'($urandom_range(64, 8));
            default: c.blksize_request = 16'($urandom_range(65464));
        endcase
        case ($urandom_range(2))
            0: c.timeout_request = 8'd0;
            1: c.timeout_request = 8'd255;
            default: c.timeout_request = 8'($urandom);
        endcase
        c.tsize_request = 1'($urandom);
        c.dally_enable  = 1'($urandom);
        return c;
    endfunction

    // One transfer: start, mostly well-formed OACK and DATA, with some noise mixed in.
    task automatic rand_session();
        pkt_t        p;
        int          nblk;
        int          roll;
        int          lim;
        logic [15:0] full;
        p = rand_pkt();
        p.func = FUNC_START;
        push_pkt(p, 1'b0, NO_RES);
        if ($urandom_range(99) < 60) begin
            p = rand_pkt();
            p.func = FUNC_OACK;
            if ($urandom_range(99) < 80) begin
                p.option_flags  = 8'd0;
                p.size_accepted = 1'b1;
                p.app_accepts   = 1'b1;
                if (tb_cfg.blksize_request != 16'd0 && $urandom_range(1)) begin
                    p.option_flags |= F_BLK;
                    lim = (tb_cfg.blksize_request < 64) ? tb_cfg.blksize_request : 64;
                    if ($urandom_range(9) == 0)
                        p.blksize_value = tb_cfg.blksize_request;
                    else
                        p.blksize_value = 16'($urandom_range(lim, 0));
                end
                if (tb_cfg.timeout_request != 8'd0 && $urandom_range(1)) begin
                    p.option_flags |= F_TMO;
                    p.timeout_value = tb_cfg.timeout_request;
                end
                if (tb_cfg.tsize_request && $urandom_range(1))
                    p.option_flags |= F_TSZ;
                if ($urandom_range(9) == 0)
                    p.option_flags[$urandom_range(7)] ^= 1'b1;
            end
            push_pkt(p, 1'b0, NO_RES);
        end
        nblk = $urandom_range(6, 1);
        for (int k = 0; k < nblk; k++) begin
            if (!(m_phase inside {XF_RECV, XF_DALLY}))
                break;
            p = rand_pkt();
            p.func = FUNC_DATA;
            p.app_accepts = ($urandom_range(99) < 85);
            full = m_rxsize;
            roll = $urandom_range(99);
            if (roll < 8) begin
                p.block_number = m_last;
                p.data_size    = full;
            end
            else if (roll < 14) begin
                if ($urandom_range(1) && full < 16'hFFFF) begin
                    p.block_number = m_last + 16'd1;
                    p.data_size    = 16'($urandom_range(65535, full + 1));
                end
            end
            else begin
                p.block_number = m_last + 16'd1;
                if (k == nblk - 1 && $urandom_range(3) != 0 && full != 16'd0)
                    p.data_size = 16'($urandom_range(full - 1, 0));
                else
                    p.data_size = full;
            end
            push_pkt(p, 1'b0, NO_RES);
        end
        // A retried final block during dally, or a stray packet after the end.
        if (m_phase == XF_DALLY && $urandom_range(1)) begin
            p = rand_pkt();
            p.func = FUNC_DATA;
            p.block_number = m_last;
            push_pkt(p, 1'b0, NO_RES);
        end
        else if (m_phase == XF_DONE && $urandom_range(3) == 0) begin
            p = rand_pkt();
            p.func = func_t'($urandom_range(3, 1));
            push_pkt(p, 1'b0, NO_RES);
        end
    endtask

    task automatic add_pkt(input pkt_t p, input bit typed, input res_t want);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.cfg    = '0;
        row.pkt    = p;
        row.typed  = typed;
        row.want   = want;
        dir_tab.push_back(row);
    endtask

    task automatic add_cfg(input cfg_t c);
        stim_row_t row;
        row.is_cfg = 1'b1;
        row.cfg    = c;
        row.pkt    = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        dir_tab.push_back(row);
    endtask

    task automatic build_table();
        res_t ign;
        res_t rrq;
        pkt_t go;
        ign = mk_res(SEND_NONE, 16'd0, ERR_ILLEGAL_OP, FR_NONE, 1'b0, WAIT_FINISHED,
                     ST_IN_PROGRESS);
        rrq = mk_res(SEND_RRQ, 16'd0, ERR_ILLEGAL_OP, FR_NONE, 1'b0, WAIT_RECEIVE,
                     ST_IN_PROGRESS);
        go  = mk_pkt(FUNC_START, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        // Packets before any start send nothing and report that the transfer is finished.
        add_pkt(mk_pkt(FUNC_DATA, 16'd1, 16'd512, 16'd0, 8'd0, 8'd0, 1'b1, 1'b1), 1'b1, ign);
        add_pkt(mk_pkt(FUNC_START, 16'hFFFF, 16'hFFFF, 16'd65464, 8'hFF, 8'hFF, 1'b1, 1'b1),
                1'b1, rrq);
        add_pkt(mk_pkt(FUNC_ACK, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b1,
                mk_err(ERR_ILLEGAL_OP, FR_ACK_UNEXPECTED, ST_XFER_ERROR));
        add_pkt(go, 1'b1, rrq);
        add_pkt(mk_pkt(FUNC_OACK, 16'd0, 16'd0, 16'd0, 8'd0, F_EMPTY, 1'b1, 1'b1), 1'b1,
                mk_err(ERR_ILLEGAL_OP, FR_EMPTY_OACK, ST_XFER_ERROR));
        add_pkt(go, 1'b0, NO_RES);
        add_pkt(mk_pkt(FUNC_OACK, 16'd0, 16'd0, 16'd512, 8'd0, F_BLK, 1'b1, 1'b1), 1'b1,
                mk_err(ERR_OPTION_REFUSED, FR_BLKSIZE_UNEXP, ST_OPTION_ERROR));
        add_pkt(go, 1'b0, NO_RES);
        add_pkt(mk_pkt(FUNC_DATA, 16'd1, 16'd512, 16'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b1,
                mk_err(ERR_OPTION_REFUSED, FR_NO_OPTIONS, ST_XFER_ERROR));
        add_pkt(go, 1'b0, NO_RES);
        add_pkt(mk_pkt(FUNC_DATA, 16'd1, 16'd512, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1), 1'b0, NO_RES);
        // Same block again is acknowledged but not delivered.
        add_pkt(mk_pkt(FUNC_DATA, 16'd1, 16'd512, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1), 1'b0, NO_RES);
        add_pkt(mk_pkt(FUNC_DATA, 16'd3, 16'd512, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1), 1'b1,
                mk_err(ERR_ILLEGAL_OP, FR_WRONG_BLOCK, ST_XFER_ERROR));
        add_pkt(go, 1'b0, NO_RES);
        add_pkt(mk_pkt(FUNC_DATA, 16'd1, 16'hFFFF, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1), 1'b1,
                mk_err(ERR_ILLEGAL_OP, FR_TOO_MUCH_DATA, ST_XFER_ERROR));
        add_pkt(go, 1'b0, NO_RES);
        add_pkt(mk_pkt(FUNC_DATA, 16'd1, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1), 1'b0, NO_RES);
        add_cfg(cfg_t'{16'd65464, 8'd255, 1'b1, 1'b1});
        add_pkt(go, 1'b0, NO_RES);
        add_pkt(mk_pkt(FUNC_OACK, 16'd0, 16'd0, 16'd65464, 8'd255, F_BLK | F_TMO | F_TSZ,
                       1'b1, 1'b1), 1'b0, NO_RES);
        // A second OACK before any data is checked again.
        add_pkt(mk_pkt(FUNC_OACK, 16'd0, 16'd0, 16'd65464, 8'd255, F_BLK | F_UNK,
                       1'b1, 1'b1), 1'b1,
                mk_err(ERR_OPTION_REFUSED, FR_UNKNOWN_OPTIONS, ST_OPTION_ERROR));
        add_pkt(go, 1'b0, NO_RES);
        add_pkt(mk_pkt(FUNC_OACK, 16'd0, 16'd0, 16'd0, 8'd0, F_TSZ, 1'b0, 1'b1), 1'b1,
                mk_err(ERR_DISK_FULL, FR_TSIZE_REFUSED, ST_OPTION_ERROR));
        add_pkt(go, 1'b0, NO_RES);
        add_pkt(mk_pkt(FUNC_DATA, 16'd1, 16'd100, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1), 1'b0, NO_RES);
        // In dally, an OACK is treated as during the transfer.
        add_pkt(mk_pkt(FUNC_OACK, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b1, 1'b1), 1'b1,
                mk_err(ERR_ILLEGAL_OP, FR_OACK_AFTER_DATA, ST_XFER_ERROR));
    endtask

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        pkt_t p;
        int   target;
        int   sess;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_BLKSIZE_REQUEST;
        cfg_data      = '0;
        pkt_ch.valid  = 1'b0;
        pkt_ch.func   = FUNC_START;
        pkt_ch.block_number  = '0;
        pkt_ch.data_size     = '0;
        pkt_ch.blksize_value = '0;
        pkt_ch.timeout_value = '0;
        pkt_ch.option_flags  = '0;
        pkt_ch.size_accepted = 1'b0;
        pkt_ch.app_accepts   = 1'b0;
        res_ch.ready  = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        mism_count    = 0;
        live_count    = 0;
        m_last        = 16'd0;
        m_rxsize      = 16'(TRR_DEFAULT_BLOCK_SIZE);
        m_oack        = 1'b0;
        m_phase       = XF_IDLE;
        tb_cfg        = '0;
        send_idle_pct = 23;
        recv_idle_pct = 65;
        build_table();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                wait_drained();
                write_cfg(dir_tab[i].cfg);
            end
            else
                push_pkt(dir_tab[i].pkt, dir_tab[i].typed, dir_tab[i].want);
        end

        for (int stage = 0; stage < 3; stage++) begin
            send_idle_pct = (stage == 0) ? 23 : (stage == 1) ? 65 : 0;
            recv_idle_pct = (stage == 0) ? 65 : (stage == 1) ? 23 : 0;
            target = live_count + 150;
            sess   = 0;
            while (live_count < target) begin
                if (sess % 4 == 0) begin
                    wait_drained();
                    write_cfg(rand_cfg());
                end
                // Long hold-off on the result side while packets keep coming.
                if (stage == 2 && sess == 1)
                    hold_req = 1'b1;
                rand_session();
                sess++;
            end
        end

        // One plain transfer with default options, full-size blocks and a short last one.
        wait_drained();
        write_cfg(cfg_t'{16'd0, 8'd0, 1'b0, 1'b0});
        p = mk_pkt(FUNC_START, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0, 1'b1);
        push_pkt(p, 1'b0, NO_RES);
        p.func = FUNC_DATA;
        for (int i = 0; i < 8; i++) begin
            p.block_number = m_last + 16'd1;
            p.data_size    = m_rxsize;
            push_pkt(p, 1'b0, NO_RES);
        end
        p.block_number = m_last + 16'd1;
        p.data_size    = 16'd7;
        push_pkt(p, 1'b0, NO_RES);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mism_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== tftp_read_receiver.f =====
rtl/core/trr_pkg.sv
rtl/core/trr_ifs.sv
rtl/core/trr_cfg_regs.sv
rtl/core/trr_in_reg.sv
rtl/core/trr_engine.sv
rtl/core/trr_out_reg.sv
rtl/core/tftp_read_receiver.sv
bench/tb_top.sv
